// File: hw/rtl/qtd_pkg.sv
// ----------------------------------------------------------------------------
// qtd_pkg
// Shared types and constants of the quadtree image decoder.
// ----------------------------------------------------------------------------
package qtd_pkg;

  localparam int unsigned MAX_LEVELS_DEF = 10;
  localparam int unsigned COORD_BITS     = 10;
  localparam int unsigned SIDE_W         = 4;
  localparam int unsigned SYM_W          = 8;
  localparam int unsigned KIND_W         = 2;
  localparam int unsigned APB_AW         = 3;
  localparam int unsigned APB_DW         = 32;

  localparam logic [SYM_W-1:0]  SYM_WHITE  = 8'h77;
  localparam logic [SYM_W-1:0]  SYM_BLACK  = 8'h62;
  localparam logic [SIDE_W-1:0] SIDE_RESET = 4'd2;

  // Register index, taken from the word address
  localparam logic REG_SIDE_LOG2 = 1'b0;

  localparam logic [KIND_W-1:0] KIND_SPLIT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WHITE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BLACK = 2'd2;
  localparam logic [KIND_W-1:0] KIND_ERROR = 2'd3;

  // Child positions within a split square
  localparam logic [1:0] CHILD_TR = 2'd0;
  localparam logic [1:0] CHILD_BL = 2'd2;
  localparam logic [1:0] CHILD_BR = 2'd3;

  typedef struct packed {
    logic [SIDE_W-1:0] eff_side;
    logic              restart;
  } qtd_ctrl_t;

  typedef struct packed {
    logic [KIND_W-1:0]     kind;
    logic [COORD_BITS-1:0] row;
    logic [COORD_BITS-1:0] col;
    logic [SIDE_W-1:0]     size_log2;
    logic                  last;
  } qtd_res_t;

endpackage

// File: hw/rtl/qtd_cfg.sv
// ----------------------------------------------------------------------------
// qtd_cfg
// APB register block: holds side_log2, clamps it, and pulses a restart on
// every write to it.
// ----------------------------------------------------------------------------
module qtd_cfg #(
  parameter int unsigned MAX_LEVELS = qtd_pkg::MAX_LEVELS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [qtd_pkg::APB_AW-1:0]  cfg_paddr,
  input  logic [qtd_pkg::APB_DW-1:0]  cfg_pwdata,
  output logic [qtd_pkg::APB_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready,
  output qtd_pkg::qtd_ctrl_t          ctrl
);
  import qtd_pkg::*;

  localparam int unsigned EFF_LIM =
    (MAX_LEVELS < COORD_BITS) ? MAX_LEVELS : COORD_BITS;

  logic [SIDE_W-1:0] side_r;
  logic [SIDE_W-1:0] side_nxt;
  logic              restart_r;
  logic              restart_nxt;
  logic              wr_side;

  assign cfg_pready = 1'b1;
  assign wr_side = cfg_psel && cfg_penable && cfg_pwrite &&
                   (cfg_paddr[2] == REG_SIDE_LOG2);

  always_comb begin
    side_nxt    = wr_side ? cfg_pwdata[SIDE_W-1:0] : side_r;
    restart_nxt = wr_side;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r    <= SIDE_RESET;
      restart_r <= 1'b0;
    end else begin
      side_r    <= side_nxt;
      restart_r <= restart_nxt;
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == REG_SIDE_LOG2) begin
      cfg_prdata[SIDE_W-1:0] = side_r;
    end
  end

  always_comb begin
    ctrl.restart = restart_r;
    if ({1'b0, side_r} > (SIDE_W+1)'(EFF_LIM)) begin
      ctrl.eff_side = SIDE_W'(EFF_LIM);
    end else begin
      ctrl.eff_side = side_r;
    end
  end

endmodule

// File: hw/rtl/qtd_walk.sv
// ----------------------------------------------------------------------------
// qtd_walk
// Tree walker: child stack and level, square position from the stack, and
// the push / pop-and-advance update for one symbol.
// ----------------------------------------------------------------------------
module qtd_walk #(
  parameter int unsigned MAX_LEVELS = qtd_pkg::MAX_LEVELS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  qtd_pkg::qtd_ctrl_t         ctrl,
  input  logic                       adv,
  input  logic [qtd_pkg::SYM_W-1:0]  sym,
  output qtd_pkg::qtd_res_t          res
);
  import qtd_pkg::*;

  localparam int unsigned LVL_W = $clog2(MAX_LEVELS + 1);
  localparam int unsigned CMP_W = (LVL_W > SIDE_W) ? LVL_W : SIDE_W;

  logic [1:0]       stack_r   [MAX_LEVELS];
  logic [1:0]       stack_nxt [MAX_LEVELS];
  logic [LVL_W-1:0] level_r;
  logic [LVL_W-1:0] level_nxt;
  logic [LVL_W-1:0] pop_lvl;
  logic [SIDE_W-1:0] sh;
  logic [CMP_W-1:0] size_w;
  logic             leaf;
  logic [COORD_BITS-1:0] row_w;
  logic [COORD_BITS-1:0] col_w;
  logic [KIND_W-1:0]     kind_w;
  logic                  last_w;

  // Position: each stacked child may set one row bit (bottom half) and one column bit (right half)
  always_comb begin
    row_w = '0;
    col_w = '0;
    sh    = '0;
    for (int k = 0; k < MAX_LEVELS; k++) begin
      if (LVL_W'(k) < level_r) begin
        sh = ctrl.eff_side - SIDE_W'(k) - SIDE_W'(1);
        if (stack_r[k] >= CHILD_BL) begin
          row_w[sh] = 1'b1;
        end
        if (stack_r[k] == CHILD_TR || stack_r[k] == CHILD_BR) begin
          col_w[sh] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    size_w = CMP_W'(ctrl.eff_side) - CMP_W'(level_r);
    if (sym == SYM_WHITE) begin
      kind_w = KIND_WHITE;
    end else if (sym == SYM_BLACK) begin
      kind_w = KIND_BLACK;
    end else if (size_w == '0) begin
      kind_w = KIND_ERROR;
    end else begin
      kind_w = KIND_SPLIT;
    end
    leaf = (kind_w != KIND_SPLIT);
  end

  // Pop finished levels: deepest open level whose child is not the last
  always_comb begin
    pop_lvl = '0;
    for (int j = 1; j <= MAX_LEVELS; j++) begin
      if (LVL_W'(j) <= level_r && stack_r[j-1] != CHILD_BR) begin
        pop_lvl = LVL_W'(j);
      end
    end
    last_w = leaf && (pop_lvl == '0);
  end

  assign res = '{kind: kind_w, row: row_w, col: col_w,
                 size_log2: size_w[SIDE_W-1:0], last: last_w};

  always_comb begin
    level_nxt = level_r;
    for (int k = 0; k < MAX_LEVELS; k++) begin
      stack_nxt[k] = stack_r[k];
    end
    if (ctrl.restart) begin
      level_nxt = '0;
      for (int k = 0; k < MAX_LEVELS; k++) begin
        stack_nxt[k] = CHILD_TR;
      end
    end else if (adv) begin
      if (!leaf) begin
        if (level_r < LVL_W'(MAX_LEVELS)) begin
          for (int k = 0; k < MAX_LEVELS; k++) begin
            if (LVL_W'(k) == level_r) begin
              stack_nxt[k] = CHILD_TR;
            end
          end
          level_nxt = level_r + LVL_W'(1);
        end
      end else if (pop_lvl == '0) begin
        // tree done: back to the root
        level_nxt = '0;
        for (int k = 0; k < MAX_LEVELS; k++) begin
          stack_nxt[k] = CHILD_TR;
        end
      end else begin
        level_nxt = pop_lvl;
        for (int k = 0; k < MAX_LEVELS; k++) begin
          if (LVL_W'(k + 1) == pop_lvl) begin
            stack_nxt[k] = stack_r[k] + 2'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
      for (int k = 0; k < MAX_LEVELS; k++) begin
        stack_r[k] <= CHILD_TR;
      end
    end else begin
      level_r <= level_nxt;
      for (int k = 0; k < MAX_LEVELS; k++) begin
        stack_r[k] <= stack_nxt[k];
      end
    end
  end

endmodule

// File: hw/rtl/quadtree_image_decoder.sv
// ----------------------------------------------------------------------------
// quadtree_image_decoder
// Preorder quadtree code decoder: one result request per code symbol.
// ----------------------------------------------------------------------------
// Input channel in_valid / in_stall / in_symbol carries one code byte per
// request: 'w' white leaf, 'b' black leaf, anything else a split (an error at size 0). Output
// channel out_valid / out_stall returns, for each symbol, its kind, the
// square's row, column and size_log2, and last on the symbol that completes
// the tree; the next symbol then starts a new image.
// A symbol passes the input register, then the result register; throughput is
// one symbol per cycle while out_stall is low, set by the walker's stack update.
// When out_stall is held, the result register and the input register fill
// and in_stall rises; nothing is dropped.
// Reset sets side_log2 to 2 and puts the walker at the root. A write to
// side_log2 through the APB port (address 0) also returns to the root; write
// it only while no symbol is in flight.
// ----------------------------------------------------------------------------
module quadtree_image_decoder #(
  parameter int unsigned MAX_LEVELS = qtd_pkg::MAX_LEVELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [qtd_pkg::SYM_W-1:0]       in_symbol,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [qtd_pkg::KIND_W-1:0]      out_kind,
  output logic [qtd_pkg::COORD_BITS-1:0]  out_row,
  output logic [qtd_pkg::COORD_BITS-1:0]  out_col,
  output logic [qtd_pkg::SIDE_W-1:0]      out_size_log2,
  output logic                            out_last,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [qtd_pkg::APB_AW-1:0]      cfg_paddr,
  input  logic [qtd_pkg::APB_DW-1:0]      cfg_pwdata,
  output logic [qtd_pkg::APB_DW-1:0]      cfg_prdata,
  output logic                            cfg_pready
);
  import qtd_pkg::*;

  qtd_ctrl_t        ctrl;
  qtd_res_t         res;
  qtd_res_t         res_r;
  logic             s1_v_r;
  logic             s1_v_nxt;
  logic [SYM_W-1:0] s1_sym_r;
  logic             out_v_r;
  logic             out_v_nxt;
  logic             s2_ld;
  logic             adv;
  logic             in_acc;

  qtd_cfg #(
    .MAX_LEVELS (MAX_LEVELS)
  ) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .ctrl        (ctrl)
  );

  qtd_walk #(
    .MAX_LEVELS (MAX_LEVELS)
  ) u_walk (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (ctrl),
    .adv   (adv),
    .sym   (s1_sym_r),
    .res   (res)
  );

  // Result register loads when empty or being taken
  assign s2_ld    = !out_v_r || !out_stall;
  assign adv      = s1_v_r && s2_ld;
  assign in_stall = s1_v_r && !s2_ld;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    s1_v_nxt  = in_acc ? 1'b1 : (adv ? 1'b0 : s1_v_r);
    out_v_nxt = s2_ld ? adv : out_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_sym_r <= in_symbol;
    end
    if (adv) begin
      res_r <= res;
    end
  end

  assign out_valid     = out_v_r;
  assign out_kind      = res_r.kind;
  assign out_row       = res_r.row;
  assign out_col       = res_r.col;
  assign out_size_log2 = res_r.size_log2;
  assign out_last      = res_r.last;

endmodule
